[hdl/rsut_pkg.sv]
// ----------------------------------------------------------------------------
// rsut_pkg - shared types and constants for the range-sum tree
// Field widths, opcode codes and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package rsut_pkg;

  localparam int POS_W   = 10;
  localparam int DATA_W  = 32;
  localparam int RANGE_W = 11;
  localparam int SIZE_W  = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic clr_step;  // write zero at clear pointer
    logic upd_leaf;  // write new leaf value
    logic upd_rd;    // read sibling of current node
    logic upd_wr;    // write parent = current + sibling
    logic q_rd_lo;   // read node at left bound, advance it
    logic q_rd_hi;   // read node below right bound
    logic q_shift;   // move both bounds one level up
    logic out_load;  // present result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic upd_ok;
    logic node_gt1;
    logic parent_gt1;
    logic lo_lt_hi;
    logic lo_odd;
    logic hi_odd;
    logic out_free;
  } sts_t;

endpackage

[hdl/rsut_in_if.sv]
// ----------------------------------------------------------------------------
// rsut_in_if - input channel of the range-sum tree
// Valid/ready channel carrying one update or query transaction.
// ----------------------------------------------------------------------------
interface rsut_in_if;
  import rsut_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic [RANGE_W-1:0]       range_left;
  logic [RANGE_W-1:0]       range_right;

  modport source (
    output valid, opcode, position, value, range_left, range_right,
    input  ready
  );

  modport sink (
    input  valid, opcode, position, value, range_left, range_right,
    output ready
  );

endinterface

[hdl/rsut_out_if.sv]
// ----------------------------------------------------------------------------
// rsut_out_if - result channel of the range-sum tree
// Valid/ready channel carrying one acknowledgement or query answer.
// ----------------------------------------------------------------------------
interface rsut_out_if;
  import rsut_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     was_query;
  logic signed [DATA_W-1:0] range_sum;

  modport source (
    output valid, was_query, range_sum,
    input  ready
  );

  modport sink (
    input  valid, was_query, range_sum,
    output ready
  );

endinterface

[hdl/rsut_cfg_if.sv]
// ----------------------------------------------------------------------------
// rsut_cfg_if - configuration write channel
// Valid/ready channel carrying the size-in-use register value.
// ----------------------------------------------------------------------------
interface rsut_cfg_if;
  import rsut_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_in_use;

  modport source (
    output valid, size_in_use,
    input  ready
  );

  modport sink (
    input  valid, size_in_use,
    output ready
  );

endinterface

[hdl/range_sum_point_update_tree.sv]
// ----------------------------------------------------------------------------
// range_sum_point_update_tree - segment tree with point update and range sum
// Top level: joins the sequencer and the datapath to the three channels.
// ----------------------------------------------------------------------------
// Holds LEAVES signed 32-bit values in an iterative sum tree kept in one
// single-port node memory of 2*LEAVES words. An update transaction writes
// one leaf and rewrites every sum on its path to the root; a query
// transaction returns the wrapped sum over [range_left, range_right), both
// ends clipped to min(size_in_use, LEAVES). Every transaction gives exactly
// one result. After reset the block clears the node memory and takes no
// transaction meanwhile; configuration writes are taken at any time. The
// single memory port sets the pace: an update does one read and one write
// per level on its way to the root, a query walks up one level at a time
// (the full range walking log2(LEAVES)+1 levels) with one read per odd
// bound. Items are handled one at a time; a finished result waits in the
// output register while the next transaction runs.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree #(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rsut_in_if.sink     in_ch,
  rsut_out_if.source  out_ch,
  rsut_cfg_if.sink    cfg_ch
);
  import rsut_pkg::*;

  cmd_t cmd;    // sequencer commands
  sts_t sts;    // datapath status
  logic in_rdy;

  // size register may change at any time; the user only writes it when idle
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_rdy;

  rsut_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsut_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_ch.opcode),
    .in_position    (in_ch.position),
    .in_value       (in_ch.value),
    .in_range_left  (in_ch.range_left),
    .in_range_right (in_ch.range_right),
    .cfg_we         (cfg_ch.valid),
    .cfg_size       (cfg_ch.size_in_use),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_was_query  (out_ch.was_query),
    .out_range_sum  (out_ch.range_sum)
  );

endmodule

[hdl/rsut_ctrl.sv]
// ----------------------------------------------------------------------------
// rsut_ctrl - sequencer for the range-sum tree
// Walks the clear sweep, update path and query loop by issuing datapath
// commands from datapath status.
// ----------------------------------------------------------------------------
module rsut_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsut_pkg::sts_t sts,
  output rsut_pkg::cmd_t cmd
);
  import rsut_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_DECODE   = 9'b000000100,
    ST_UPD_LEAF = 9'b000001000,
    ST_UPD_RD   = 9'b000010000,
    ST_UPD_WR   = 9'b000100000,
    ST_Q_LO     = 9'b001000000,
    ST_Q_HI     = 9'b010000000,
    ST_FIN      = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_query)    state_nxt = ST_Q_LO;
        else if (sts.upd_ok) state_nxt = ST_UPD_LEAF;
        else                 state_nxt = ST_FIN;
      end
      ST_UPD_LEAF: begin
        cmd.upd_leaf = 1'b1;
        state_nxt    = sts.node_gt1 ? ST_UPD_RD : ST_FIN;
      end
      ST_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = sts.parent_gt1 ? ST_UPD_RD : ST_FIN;
      end
      ST_Q_LO: begin
        if (!sts.lo_lt_hi) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.q_rd_lo = sts.lo_odd;
          state_nxt   = ST_Q_HI;
        end
      end
      ST_Q_HI: begin
        cmd.q_rd_hi = sts.hi_odd;
        cmd.q_shift = 1'b1;
        state_nxt   = ST_Q_LO;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

[hdl/rsut_dp.sv]
// ----------------------------------------------------------------------------
// rsut_dp - datapath of the range-sum tree
// Node memory (single port), bound/index registers, accumulator, size
// register and result register.
// ----------------------------------------------------------------------------
module rsut_dp #(
  parameter int LEAVES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rsut_pkg::cmd_t                     cmd,
  output rsut_pkg::sts_t                     sts,
  input  logic                               in_opcode,
  input  logic [rsut_pkg::POS_W-1:0]         in_position,
  input  logic signed [rsut_pkg::DATA_W-1:0] in_value,
  input  logic [rsut_pkg::RANGE_W-1:0]       in_range_left,
  input  logic [rsut_pkg::RANGE_W-1:0]       in_range_right,
  input  logic                               cfg_we,
  input  logic [rsut_pkg::SIZE_W-1:0]        cfg_size,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_was_query,
  output logic signed [rsut_pkg::DATA_W-1:0] out_range_sum
);
  import rsut_pkg::*;

  localparam int DEPTH = 2 * LEAVES;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = IW + 1;                       // bounds reach 2*LEAVES
  localparam int EW    = (CW > SIZE_W) ? CW : SIZE_W;

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  logic [SIZE_W-1:0] size_r,      size_nxt;
  logic [IW-1:0]     clr_cnt_r,   clr_cnt_nxt;
  logic [CW-1:0]     lo_r,        lo_nxt;
  logic [CW-1:0]     hi_r,        hi_nxt;
  logic [DATA_W-1:0] acc_r,       acc_nxt;
  logic              add_pend_r,  add_pend_nxt;
  logic              op_r,        op_nxt;
  logic              upd_ok_r,    upd_ok_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_query_r, out_query_nxt;
  logic [DATA_W-1:0] out_sum_r,   out_sum_nxt;

  logic [EW-1:0]     size_e, leaves_e, n_e, pos_e, left_e, right_e, lo_c, hi_c;
  logic [CW-1:0]     lo_node, hi_node, hi_dec;
  logic [DATA_W-1:0] sum;
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;

  // effective size and clipped bounds
  always_comb begin
    size_e   = EW'(size_r);
    leaves_e = EW'(LEAVES);
    n_e      = (size_e > leaves_e) ? leaves_e : size_e;
    pos_e    = EW'(in_position);
    left_e   = EW'(in_range_left);
    right_e  = EW'(in_range_right);
    lo_c     = (left_e > n_e) ? n_e : left_e;
    hi_c     = (right_e > n_e) ? n_e : right_e;
    lo_node  = (in_opcode == OP_QUERY) ? CW'(lo_c + leaves_e) : CW'(pos_e + leaves_e);
    hi_node  = CW'(hi_c + leaves_e);
  end

  assign sum    = acc_r + rdata_r;
  assign hi_dec = hi_r - CW'(1);

  // memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = lo_r[IW-1:0];
    mem_wdata = acc_r;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.upd_leaf) begin
      mem_we    = 1'b1;
    end else if (cmd.upd_rd) begin
      mem_re    = 1'b1;
      mem_addr  = lo_r[IW-1:0] ^ IW'(1);
    end else if (cmd.upd_wr) begin
      mem_we    = 1'b1;
      mem_addr  = lo_r[IW:1];
      mem_wdata = sum;
    end else if (cmd.q_rd_lo) begin
      mem_re    = 1'b1;
    end else if (cmd.q_rd_hi) begin
      mem_re    = 1'b1;
      mem_addr  = hi_dec[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  // register next values
  always_comb begin
    size_nxt      = cfg_we ? cfg_size : size_r;
    clr_cnt_nxt   = cmd.clr_step ? clr_cnt_r + IW'(1) : clr_cnt_r;
    op_nxt        = op_r;
    upd_ok_nxt    = upd_ok_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    add_pend_nxt  = cmd.q_rd_lo | cmd.q_rd_hi;
    out_valid_nxt = out_valid_r;
    out_query_nxt = out_query_r;
    out_sum_nxt   = out_sum_r;

    if (cmd.load) begin
      op_nxt     = (in_opcode == OP_QUERY);
      upd_ok_nxt = (pos_e < n_e);
      lo_nxt     = lo_node;
      hi_nxt     = hi_node;
      acc_nxt    = (in_opcode == OP_QUERY) ? '0 : DATA_W'(in_value);
    end else begin
      if (cmd.upd_wr || add_pend_r) acc_nxt = sum;
      if (cmd.upd_wr || cmd.q_shift) lo_nxt = lo_r >> 1;
      else if (cmd.q_rd_lo)          lo_nxt = lo_r + CW'(1);
      // right bound is odd when read, so (hi-1)>>1 equals hi>>1
      if (cmd.q_shift) hi_nxt = hi_r >> 1;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_query_nxt = op_r;
      out_sum_nxt   = op_r ? acc_r : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      clr_cnt_r   <= '0;
      add_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      add_pend_r  <= add_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    upd_ok_r    <= upd_ok_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    acc_r       <= acc_nxt;
    out_query_r <= out_query_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  // status
  always_comb begin
    sts.clr_last   = (clr_cnt_r == IW'(DEPTH - 1));
    sts.is_query   = op_r;
    sts.upd_ok     = upd_ok_r;
    sts.node_gt1   = (lo_r > CW'(1));
    sts.parent_gt1 = (lo_r > CW'(3));
    sts.lo_lt_hi   = (lo_r < hi_r);
    sts.lo_odd     = lo_r[0];
    sts.hi_odd     = hi_r[0];
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_was_query = out_query_r;
  assign out_range_sum = out_sum_r;

  // checks
  a_lo_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_rd_lo |-> (lo_r[0] && (lo_r < hi_r)))
    else $error("left-bound read outside live range");

  a_hi_read_odd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_rd_hi |-> (hi_r[0] && op_r))
    else $error("right-bound read on even bound or outside a query");

  a_parent_after_sibling: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_wr |-> $past(cmd.upd_rd))
    else $error("parent write without sibling read");

  a_leaf_only_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_leaf |-> (upd_ok_r && !op_r))
    else $error("leaf written for ignored or query transaction");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

endmodule
